/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define FSIF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define FSIF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   `FSIF_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

// next-cycle implication
`define FSIF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `FSIF_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

/* src/fsif_pkg.sv */
// types, constants and codes of the integer format-string formatter
package fsif_pkg;

   localparam int MAX_WIDTH_DEF  = 63;
   localparam int COUNT_BITS_DEF = 16;

   // reciprocal of ten, exact for 32-bit operands with a 35-bit shift
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          MAX_DIGITS  = 10;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_U     = 8'h75;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_FLAGS,
      PH_WIDTH,
      PH_SPEC
   } fsif_phase_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_TEXT,
      ACT_PCT,
      ACT_CONV_S,
      ACT_CONV_U,
      ACT_END
   } fsif_act_type;

   typedef enum logic [2:0] {
      EM_TEXT,
      EM_PCT,
      EM_PAD,
      EM_SIGN,
      EM_DIGIT,
      EM_TERM
   } fsif_emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_MUL,
      ST_DIV_SUB,
      ST_LAYOUT,
      ST_PAD,
      ST_SIGN,
      ST_DIGIT,
      ST_EMIT
   } fsif_state_type;

   typedef struct packed {
      logic          capture;
      logic          decode;
      logic          start_conv;
      logic          mul;
      logic          sub;
      logic          emit;
      fsif_emit_type emit_sel;
      logic          last;
   } fsif_cmd_type;

   typedef struct packed {
      fsif_act_type act_now;
      fsif_act_type act_held;
      logic         out_free;
      logic         conv_done;
      logic         zero_pad;
      logic         neg;
      logic         pad_zero;
      logic         pad_one;
      logic         digit_last;
   } fsif_status_type;

endpackage

/* src/fsif_ctrl.sv */
// sequencer of the formatter: decode, digit extraction and emission order
module fsif_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fsif_pkg::fsif_status_type status,
   output fsif_pkg::fsif_cmd_type    cmd
);
   import fsif_pkg::*;

   fsif_state_type state_ff;
   fsif_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.act_now)
               ACT_TEXT, ACT_PCT, ACT_END: state_in = ST_EMIT;
               ACT_CONV_S, ACT_CONV_U:     state_in = ST_DIV_MUL;
               default:                    state_in = ST_IDLE;
            endcase
         end
         ST_DIV_MUL: state_in = ST_DIV_SUB;
         ST_DIV_SUB: begin
            state_in = status.conv_done ? ST_LAYOUT : ST_DIV_MUL;
         end
         ST_LAYOUT: begin
            if (status.zero_pad) begin
               if (status.neg)           state_in = ST_SIGN;
               else if (status.pad_zero) state_in = ST_DIGIT;
               else                      state_in = ST_PAD;
            end else begin
               if (!status.pad_zero)     state_in = ST_PAD;
               else if (status.neg)      state_in = ST_SIGN;
               else                      state_in = ST_DIGIT;
            end
         end
         ST_PAD: begin
            if (status.out_free && status.pad_one) begin
               if (!status.zero_pad && status.neg) state_in = ST_SIGN;
               else                                state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               if (status.zero_pad && !status.pad_zero) state_in = ST_PAD;
               else                                     state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free && status.digit_last) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.decode     = 1'b1;
            cmd.start_conv = (status.act_now == ACT_CONV_S) ||
                             (status.act_now == ACT_CONV_U);
         end
         ST_DIV_MUL: cmd.mul = 1'b1;
         ST_DIV_SUB: cmd.sub = 1'b1;
         ST_PAD: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EM_PAD;
         end
         ST_SIGN: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EM_SIGN;
         end
         ST_DIGIT: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EM_DIGIT;
            cmd.last     = status.digit_last;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
            cmd.last = 1'b1;
            case (status.act_held)
               ACT_PCT: cmd.emit_sel = EM_PCT;
               ACT_END: cmd.emit_sel = EM_TERM;
               default: cmd.emit_sel = EM_TEXT;
            endcase
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* src/fsif_datapath.sv */
// formatter datapath: spec state, digit extraction, counters and output register
module fsif_datapath #(
   parameter int MaxWidth  = fsif_pkg::MAX_WIDTH_DEF,
   parameter int CountBits = fsif_pkg::COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_fmt_char,
   input  logic [31:0]               req_arg_bits,
   input  logic                      csr_write,
   input  logic [15:0]               csr_buffer_size,
   input  fsif_pkg::fsif_cmd_type    cmd,
   output fsif_pkg::fsif_status_type status,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_char,
   output logic [15:0]               rsp_position,
   output logic                      rsp_stored,
   output logic                      rsp_is_end,
   output logic [15:0]               rsp_total_length,
   output logic                      rsp_last
);
   import fsif_pkg::*;

   localparam int CntW = (CountBits > 16) ? CountBits : 16;
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   // spec state and configuration
   fsif_phase_type       phase_ff, phase_in;
   logic                 zp_ff, zp_in;
   logic [5:0]           pw_ff, pw_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [15:0]          bs_ff, bs_in;

   // item registers
   logic [7:0]           char_ff, char_in;
   logic [31:0]          arg_ff, arg_in;
   fsif_act_type         act_ff, act_in;

   // conversion registers
   logic [31:0]          mag_ff, mag_in;
   logic [63:0]          prod_ff, prod_in;
   logic                 neg_ff, neg_in;
   logic [3:0]           nd_ff, nd_in;
   logic [5:0]           pad_ff, pad_in;
   logic [3:0]           dig_ff [MAX_DIGITS];

   // output register
   logic                 rv_ff, rv_in;
   logic [7:0]           rch_ff, rch_in;
   logic [15:0]          rpos_ff, rpos_in;
   logic                 rst_ff, rst_in;
   logic                 rend_ff, rend_in;
   logic [15:0]          rlen_ff, rlen_in;
   logic                 rlast_ff, rlast_in;

   // decode
   fsif_act_type   act_now;
   fsif_phase_type phase_dec;
   logic           zp_dec;
   logic [5:0]     pw_dec;
   logic           dec_done;
   logic           is_digit;
   logic [9:0]     w_sum;

   // arithmetic
   logic [31:0]    quot;
   logic [31:0]    rem_full;
   logic [3:0]     nd_next;
   logic [3:0]     len;
   logic [CntW-1:0] cnt_ext;
   logic [CntW-1:0] bs_ext;
   logic [CntW-1:0] lim;
   logic [15:0]    cnt_sat;
   logic           out_free;
   logic [3:0]     rd_idx;

   assign is_digit = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign w_sum    = ({4'd0, pw_ff} << 3) + ({4'd0, pw_ff} << 1) +
                     {6'd0, char_ff[3:0]};

   always_comb begin
      act_now   = ACT_NONE;
      phase_dec = phase_ff;
      zp_dec    = zp_ff;
      pw_dec    = pw_ff;
      dec_done  = 1'b0;
      if (char_ff == CH_NUL) begin
         act_now  = ACT_END;
         dec_done = 1'b1;
      end
      if (!dec_done && phase_dec == PH_TEXT) begin
         if (char_ff == CH_PCT) begin
            phase_dec = PH_FLAGS;
            zp_dec    = 1'b0;
            pw_dec    = '0;
         end else begin
            act_now = ACT_TEXT;
         end
         dec_done = 1'b1;
      end
      if (!dec_done && phase_dec == PH_FLAGS) begin
         if (char_ff == CH_ZERO) begin
            zp_dec   = 1'b1;
            dec_done = 1'b1;
         end else begin
            phase_dec = PH_WIDTH;
         end
      end
      if (!dec_done && phase_dec == PH_WIDTH) begin
         if (is_digit) begin
            pw_dec   = (w_sum > 10'(MaxWidth)) ? 6'(MaxWidth) : w_sum[5:0];
            dec_done = 1'b1;
         end else begin
            phase_dec = PH_SPEC;
         end
      end
      if (!dec_done && phase_dec == PH_SPEC) begin
         if (char_ff == CH_PCT) begin
            act_now   = ACT_PCT;
            phase_dec = PH_TEXT;
         end else if (char_ff == CH_D || char_ff == CH_I) begin
            act_now   = ACT_CONV_S;
            phase_dec = PH_TEXT;
         end else if (char_ff == CH_U) begin
            act_now   = ACT_CONV_U;
            phase_dec = PH_TEXT;
         end
      end
   end

   // one decimal digit per multiply and subtract pair
   assign quot     = {3'd0, prod_ff[63:RECIP_SHIFT]};
   assign rem_full = mag_ff - ((quot << 3) + (quot << 1));
   assign nd_next  = nd_ff + 4'd1;
   assign len      = nd_next + {3'd0, neg_ff};
   assign rd_idx   = nd_ff - 4'd1;

   assign cnt_ext  = CntW'(count_ff);
   assign bs_ext   = CntW'(bs_ff);
   assign lim      = bs_ext - CntW'(1);
   assign cnt_sat  = (cnt_ext > CntW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      phase_in = phase_ff;
      zp_in    = zp_ff;
      pw_in    = pw_ff;
      count_in = count_ff;
      bs_in    = csr_write ? csr_buffer_size : bs_ff;
      char_in  = cmd.capture ? req_fmt_char : char_ff;
      arg_in   = cmd.capture ? req_arg_bits : arg_ff;
      act_in   = act_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      nd_in    = nd_ff;
      pad_in   = pad_ff;
      rv_in    = rv_ff && rsp_stall;
      rch_in   = rch_ff;
      rpos_in  = rpos_ff;
      rst_in   = rst_ff;
      rend_in  = rend_ff;
      rlen_in  = rlen_ff;
      rlast_in = rlast_ff;

      if (cmd.decode) begin
         phase_in = phase_dec;
         zp_in    = zp_dec;
         pw_in    = pw_dec;
         act_in   = act_now;
      end
      if (cmd.start_conv) begin
         neg_in = (act_now == ACT_CONV_S) && arg_ff[31];
         mag_in = ((act_now == ACT_CONV_S) && arg_ff[31]) ? (32'd0 - arg_ff) : arg_ff;
         nd_in  = '0;
      end
      if (cmd.mul) begin
         prod_in = {32'd0, mag_ff} * {32'd0, RECIP_TEN};
      end
      if (cmd.sub) begin
         mag_in = quot;
         nd_in  = nd_next;
         pad_in = ({2'd0, len} < pw_ff) ? (pw_ff - {2'd0, len}) : 6'd0;
      end

      if (cmd.emit) begin
         rv_in    = 1'b1;
         rlast_in = cmd.last;
         rend_in  = 1'b0;
         rlen_in  = '0;
         rpos_in  = cnt_sat;
         rst_in   = (count_ff != CountMax) &&
                    ({1'b0, cnt_ext} + {{CntW{1'b0}}, 1'b1} < {1'b0, bs_ext});
         if (count_ff != CountMax) count_in = count_ff + CountBits'(1);
         case (cmd.emit_sel)
            EM_TEXT:  rch_in = char_ff;
            EM_PCT:   rch_in = CH_PCT;
            EM_PAD:   rch_in = zp_ff ? CH_ZERO : CH_SPACE;
            EM_SIGN:  rch_in = CH_MINUS;
            EM_DIGIT: rch_in = CH_ZERO + {4'd0, dig_ff[rd_idx]};
            default:  rch_in = CH_NUL;
         endcase
         case (cmd.emit_sel)
            EM_PAD:   pad_in = pad_ff - 6'd1;
            EM_DIGIT: nd_in  = rd_idx;
            EM_TERM: begin
               rend_in  = 1'b1;
               rlen_in  = cnt_sat;
               rst_in   = (bs_ff != 16'd0);
               if (bs_ff == 16'd0) rpos_in = '0;
               else rpos_in = (cnt_ext < lim) ? cnt_ext[15:0] : lim[15:0];
               phase_in = PH_TEXT;
               zp_in    = 1'b0;
               pw_in    = '0;
               count_in = '0;
            end
            default: pad_in = pad_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         zp_ff    <= 1'b0;
         pw_ff    <= '0;
         count_ff <= '0;
         bs_ff    <= '0;
         rv_ff    <= 1'b0;
         act_ff   <= ACT_NONE;
      end else begin
         phase_ff <= phase_in;
         zp_ff    <= zp_in;
         pw_ff    <= pw_in;
         count_ff <= count_in;
         bs_ff    <= bs_in;
         rv_ff    <= rv_in;
         act_ff   <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      arg_ff   <= arg_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      nd_ff    <= nd_in;
      pad_ff   <= pad_in;
      rch_ff   <= rch_in;
      rpos_ff  <= rpos_in;
      rst_ff   <= rst_in;
      rend_ff  <= rend_in;
      rlen_ff  <= rlen_in;
      rlast_ff <= rlast_in;
   end

   // digit stack, written least significant first
   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         dig_ff[nd_ff] <= rem_full[3:0];
      end
   end

   always_comb begin
      status            = '0;
      status.act_now    = act_now;
      status.act_held   = act_ff;
      status.out_free   = out_free;
      status.conv_done  = (quot == 32'd0) || (nd_next == 4'(MAX_DIGITS));
      status.zero_pad   = zp_ff;
      status.neg        = neg_ff;
      status.pad_zero   = (pad_ff == 6'd0);
      status.pad_one    = (pad_ff == 6'd1);
      status.digit_last = (nd_ff == 4'd1);
   end

   assign rsp_valid        = rv_ff;
   assign rsp_out_char     = rch_ff;
   assign rsp_position     = rpos_ff;
   assign rsp_stored       = rst_ff;
   assign rsp_is_end       = rend_ff;
   assign rsp_total_length = rlen_ff;
   assign rsp_last         = rlast_ff;

endmodule

/* src/format_string_integer_formatter_unit.sv */
// Integer format-string formatter, decimal subset of printf. Format bytes
// arrive one per req item with a 32-bit argument; ordinary text is copied,
// '%' opens a spec (leading '0' selects zero padding, then digits give a
// width saturating at MaxWidth), and 'd'/'i', 'u' or '%' complete it. Each
// rsp item carries its buffer position and whether it fits in buffer_size;
// a NUL byte emits the terminator with the total length and starts a new
// string. An input byte is first captured and then decoded; text, '%%' and
// the terminator then leave through the output register. A conversion
// takes a reciprocal multiply step and a remainder step per decimal digit
// (up to ten digits), a layout step for the field, and then emits one
// character per cycle, up to 63, whenever rsp_stall is low. There is no
// clearing pass after reset.
module format_string_integer_formatter_unit #(
   parameter int MaxWidth  = fsif_pkg::MAX_WIDTH_DEF,
   parameter int CountBits = fsif_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // format byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_fmt_char,
   input  logic [31:0] req_arg_bits,
   // buffer size register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_buffer_size,
   // output character channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic [15:0] rsp_position,
   output logic        rsp_stored,
   output logic        rsp_is_end,
   output logic [15:0] rsp_total_length,
   output logic        rsp_last
);
   import fsif_pkg::*;

   fsif_cmd_type    cmd;
   fsif_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: one item in flight, orders pad, sign and digits
   fsif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: spec state, digit extraction and output register
   fsif_datapath #(
      .MaxWidth  (MaxWidth),
      .CountBits (CountBits)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_fmt_char     (req_fmt_char),
      .req_arg_bits     (req_arg_bits),
      .csr_write        (csr_valid && csr_ready),
      .csr_buffer_size  (csr_buffer_size),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_position     (rsp_position),
      .rsp_stored       (rsp_stored),
      .rsp_is_end       (rsp_is_end),
      .rsp_total_length (rsp_total_length),
      .rsp_last         (rsp_last)
   );

endmodule

/* src/fsif_checker.sv */
// port-level checks of the formatter and their binding to the top level
`include "assert_macros.svh"

module fsif_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_char,
   input logic [15:0] rsp_position,
   input logic        rsp_is_end,
   input logic [15:0] rsp_total_length,
   input logic        rsp_last
);

   // a held result keeps its character and position
   `FSIF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_char) && $stable(rsp_position), "stalled rsp item changed")

   // terminator is a NUL and closes its input item
   `FSIF_ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && rsp_is_end, rsp_last && (rsp_out_char == 8'h00), "terminator not last or not NUL")

   // length only reported on the terminator
   `FSIF_ASSERT_IMPL(a_len_end, clock, reset, rsp_valid && !rsp_is_end, rsp_total_length == 16'd0, "length on a non-terminator item")

   // one input item at a time
   `FSIF_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second item taken while busy")

endmodule

bind format_string_integer_formatter_unit fsif_checker u_fsif_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_char     (rsp_out_char),
   .rsp_position     (rsp_position),
   .rsp_is_end       (rsp_is_end),
   .rsp_total_length (rsp_total_length),
   .rsp_last         (rsp_last)
);
